// ===== hw/rtl/esc_pkg.sv =====
// Shared constants and calendar helpers for the epoch-to-calendar converter.
package esc_pkg;

  localparam int EpochW   = 31;
  localparam int OffsetW  = 17;
  localparam int TotalW   = 32;
  localparam int DaysW    = 15;
  localparam int YearW    = 11;
  localparam int MonthW   = 4;
  localparam int DayW     = 5;
  localparam int HourW    = 5;
  localparam int MinuteW  = 6;
  localparam int SecondW  = 6;
  localparam int CountW   = 4;

  localparam logic [TotalW-1:0] DAY_SECS  = 32'd86400;
  localparam logic [TotalW-1:0] HOUR_SECS = 32'd3600;
  localparam logic [TotalW-1:0] MIN_SECS  = 32'd60;
  // One non-leap year of seconds, so the count starts at 1969-01-01.
  localparam logic [TotalW-1:0] BIAS_SECS = 32'd31536000;

  localparam logic [YearW-1:0]  BASE_YEAR   = 11'd1969;
  localparam logic [6:0]        BASE_MOD100 = 7'd69;
  localparam logic [8:0]        BASE_MOD400 = 9'd369;

  localparam logic [CountW-1:0] DAY_QBITS_TOP  = 4'd14;
  localparam logic [CountW-1:0] HOUR_QBITS_TOP = 4'd4;
  localparam logic [CountW-1:0] MIN_QBITS_TOP  = 4'd5;
  localparam logic [MonthW-1:0] LAST_MONTH     = 4'd11;
  localparam logic [MonthW-1:0] FEB            = 4'd1;

  localparam logic [OffsetW-1:0] ZONE_RESET = 17'd28800;

  // Days in a month, counted from zero for January.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mon,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      FEB:                                       len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/epoch_seconds_to_calendar_top.sv =====
// Epoch seconds to local calendar date and time, iterative converter.
//
// Input channel in_valid/in_ready carries one word: in_epoch_seconds, the
// seconds since 1970-01-01 00:00:00 UTC. The block adds the signed zone
// offset in cfg_wr_data (written with cfg_wr_en, reset value +8 hours) and
// returns one word on out_valid/out_ready: year, month, day, hour, minute
// and second of local time.
// One 33-bit subtractor is shared by every step: restoring division by
// 86400 for the day count, then the years stripped off one at a time,
// then the months one at a time, then restoring division by 3600 for the
// hour and by 60 for the minute. in_ready is low while an item is being
// converted. The finished word sits in an output register, so in_ready
// returns once it is loaded even if the receiver still stalls; a word
// that finishes while the previous one is unclaimed waits for it.
// Reset (synchronous, rst_n low) empties the output and restores the offset.
module epoch_seconds_to_calendar_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [esc_pkg::EpochW-1:0]          in_epoch_seconds,
  input  logic                                cfg_wr_en,
  input  logic signed [esc_pkg::OffsetW-1:0]  cfg_wr_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [esc_pkg::YearW-1:0]           out_year,
  output logic [esc_pkg::MonthW-1:0]          out_month_of_year,
  output logic [esc_pkg::DayW-1:0]            out_day_of_month,
  output logic [esc_pkg::HourW-1:0]           out_hour_of_day,
  output logic [esc_pkg::MinuteW-1:0]         out_minute_of_hour,
  output logic [esc_pkg::SecondW-1:0]         out_second_of_minute
);

  typedef enum logic [2:0] {
    S_IDLE, S_DAY, S_YEAR, S_MONTH, S_HOUR, S_MIN, S_FINISH
  } state_t;

  state_t                         state_r;
  logic [esc_pkg::OffsetW-1:0]    zone_r;
  logic [esc_pkg::TotalW-1:0]     rem_r;
  logic [esc_pkg::DaysW-1:0]      days_r;
  logic [esc_pkg::CountW-1:0]     cnt_r;
  logic [esc_pkg::YearW-1:0]      year_r;
  logic [6:0]                     ymod100_r;
  logic [8:0]                     ymod400_r;
  logic [esc_pkg::MonthW-1:0]     mon_r;
  logic [esc_pkg::HourW-1:0]      hour_r;
  logic [esc_pkg::MinuteW-1:0]    min_r;

  logic                           out_valid_r;
  logic [esc_pkg::YearW-1:0]      out_year_r;
  logic [esc_pkg::MonthW-1:0]     out_month_r;
  logic [esc_pkg::DayW-1:0]       out_day_r;
  logic [esc_pkg::HourW-1:0]      out_hour_r;
  logic [esc_pkg::MinuteW-1:0]    out_min_r;
  logic [esc_pkg::SecondW-1:0]    out_sec_r;

  logic [esc_pkg::TotalW-1:0]     sub_a;
  logic [esc_pkg::TotalW-1:0]     sub_b;
  logic [esc_pkg::TotalW:0]       diff;
  logic                           fits;
  logic                           leap;
  logic [esc_pkg::TotalW-1:0]     total;
  logic                           in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Offset is sign-extended; the bias keeps the local count positive.
  assign total = {1'b0, in_epoch_seconds}
               + {{(esc_pkg::TotalW-esc_pkg::OffsetW){zone_r[esc_pkg::OffsetW-1]}}, zone_r}
               + esc_pkg::BIAS_SECS;

  assign leap = (year_r[1:0] == 2'd0) && ((ymod100_r != 7'd0) || (ymod400_r == 9'd0));

  // The shared subtract-and-compare unit.
  always_comb begin
    sub_a = rem_r;
    sub_b = '0;
    case (state_r)
      S_DAY:   sub_b = esc_pkg::DAY_SECS << cnt_r;
      S_YEAR: begin
        sub_a = {{(esc_pkg::TotalW-esc_pkg::DaysW){1'b0}}, days_r};
        sub_b = leap ? 32'd366 : 32'd365;
      end
      S_MONTH: begin
        sub_a = {{(esc_pkg::TotalW-esc_pkg::DaysW){1'b0}}, days_r};
        sub_b = {{(esc_pkg::TotalW-esc_pkg::DayW){1'b0}}, esc_pkg::month_len(mon_r, leap)};
      end
      S_HOUR:  sub_b = esc_pkg::HOUR_SECS << cnt_r;
      S_MIN:   sub_b = esc_pkg::MIN_SECS << cnt_r;
      default: sub_b = '0;
    endcase
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    fits = !diff[esc_pkg::TotalW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      zone_r      <= esc_pkg::ZONE_RESET;
    end else begin
      if (cfg_wr_en) begin
        zone_r <= cfg_wr_data;
      end
      // In S_FINISH a new word may replace the one being taken.
      if (out_valid_r && out_ready && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            rem_r     <= total;
            days_r    <= '0;
            cnt_r     <= esc_pkg::DAY_QBITS_TOP;
            year_r    <= esc_pkg::BASE_YEAR;
            ymod100_r <= esc_pkg::BASE_MOD100;
            ymod400_r <= esc_pkg::BASE_MOD400;
            mon_r     <= '0;
            hour_r    <= '0;
            min_r     <= '0;
            state_r   <= S_DAY;
          end
        end
        S_DAY: begin
          if (fits) begin
            rem_r         <= diff[esc_pkg::TotalW-1:0];
            days_r[cnt_r] <= 1'b1;
          end
          if (cnt_r == '0) begin
            state_r <= S_YEAR;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_YEAR: begin
          if (fits) begin
            days_r    <= diff[esc_pkg::DaysW-1:0];
            year_r    <= year_r + 1'b1;
            ymod100_r <= (ymod100_r == 7'd99)  ? 7'd0 : ymod100_r + 1'b1;
            ymod400_r <= (ymod400_r == 9'd399) ? 9'd0 : ymod400_r + 1'b1;
          end else begin
            state_r <= S_MONTH;
          end
        end
        S_MONTH: begin
          // December takes whatever is left without a test.
          if (fits && (mon_r != esc_pkg::LAST_MONTH)) begin
            days_r <= diff[esc_pkg::DaysW-1:0];
            mon_r  <= mon_r + 1'b1;
          end else begin
            cnt_r   <= esc_pkg::HOUR_QBITS_TOP;
            state_r <= S_HOUR;
          end
        end
        S_HOUR: begin
          if (fits) begin
            rem_r              <= diff[esc_pkg::TotalW-1:0];
            hour_r[cnt_r[2:0]] <= 1'b1;
          end
          if (cnt_r == '0) begin
            cnt_r   <= esc_pkg::MIN_QBITS_TOP;
            state_r <= S_MIN;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_MIN: begin
          if (fits) begin
            rem_r             <= diff[esc_pkg::TotalW-1:0];
            min_r[cnt_r[2:0]] <= 1'b1;
          end
          if (cnt_r == '0) begin
            state_r <= S_FINISH;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_year_r  <= year_r;
            out_month_r <= mon_r + 1'b1;
            out_day_r   <= days_r[esc_pkg::DayW-1:0] + 1'b1;
            out_hour_r  <= hour_r;
            out_min_r   <= min_r;
            out_sec_r   <= rem_r[esc_pkg::SecondW-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_year             = out_year_r;
  assign out_month_of_year    = out_month_r;
  assign out_day_of_month     = out_day_r;
  assign out_hour_of_day      = out_hour_r;
  assign out_minute_of_hour   = out_min_r;
  assign out_second_of_minute = out_sec_r;

endmodule

// ===== hw/rtl/esc_checker.sv =====
// Port-level checks for the epoch-to-calendar converter, bound to the top level.
module esc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [esc_pkg::YearW-1:0]          out_year,
  input logic [esc_pkg::MonthW-1:0]         out_month_of_year,
  input logic [esc_pkg::DayW-1:0]           out_day_of_month,
  input logic [esc_pkg::HourW-1:0]          out_hour_of_day,
  input logic [esc_pkg::MinuteW-1:0]        out_minute_of_hour,
  input logic [esc_pkg::SecondW-1:0]        out_second_of_minute
);

  // A stalled word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year)
      && $stable(out_month_of_year) && $stable(out_day_of_month)
      && $stable(out_hour_of_day) && $stable(out_minute_of_hour)
      && $stable(out_second_of_minute))
    else $error("output word changed while stalled");

  // The converter is iterative, so it is busy right after a word is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input accepted again too soon");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month_of_year >= 4'd1 && out_month_of_year <= 4'd12
      && out_day_of_month >= 5'd1 && out_year >= 11'd1969 && out_year <= 11'd2038)
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hour_of_day < 5'd24 && out_minute_of_hour < 6'd60
      && out_second_of_minute < 6'd60)
    else $error("time field out of range");

endmodule

bind epoch_seconds_to_calendar_top esc_checker u_esc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_year             (out_year),
  .out_month_of_year    (out_month_of_year),
  .out_day_of_month     (out_day_of_month),
  .out_hour_of_day      (out_hour_of_day),
  .out_minute_of_hour   (out_minute_of_hour),
  .out_second_of_minute (out_second_of_minute)
);
